### rtl/psu_pkg.sv
// Package for the PNG scanline unfilter unit: payload structs, filter codes,
// configuration indexes and sizing constants. No dependencies.
package psu_pkg;

  // Longest supported row in pixels. This sets the depth of the line store.
  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned ColW      = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned CfgWidthW = 12;
  localparam int unsigned CfgHeightW = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned NumLanes  = 4;

  typedef logic [NumLanes-1:0][7:0] pix_word_t;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_ALPHA  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] filter_type;
    logic [7:0] raw_red;
    logic [7:0] raw_green;
    logic [7:0] raw_blue;
    logic [7:0] raw_alpha;
  } in_pix_t;

  typedef struct packed {
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
    logic [7:0] pix_alpha;
    logic       end_of_row;
    logic       last_pixel;
    logic       bad_filter;
  } out_pix_t;

  // Neighbour bytes and filter selection handed to one channel lane.
  typedef struct packed {
    filt_e      filt;
    logic [7:0] left;
    logic [7:0] up;
    logic [7:0] upleft;
  } lane_ctl_t;

endpackage

### rtl/psu_lane.sv
// One channel lane of the PNG unfilter unit: predictor selection and the
// modulo-256 add. Depends on psu_pkg.
module psu_lane (
  input  psu_pkg::lane_ctl_t ctl_i,
  input  logic [7:0]         raw_i,
  output logic [7:0]         pix_o
);
  import psu_pkg::*;

  logic [8:0]        avg_sum;
  logic signed [9:0] p_a, p_b, p_c;
  logic [9:0]        abs_a, abs_b, abs_c;
  logic [7:0]        paeth;
  logic [7:0]        pred;

  // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|.
  always_comb begin
    avg_sum = {1'b0, ctl_i.left} + {1'b0, ctl_i.up};
    p_a = $signed({2'b00, ctl_i.up}) - $signed({2'b00, ctl_i.upleft});
    p_b = $signed({2'b00, ctl_i.left}) - $signed({2'b00, ctl_i.upleft});
    p_c = p_a + p_b;
    abs_a = p_a[9] ? 10'(-p_a) : 10'(p_a);
    abs_b = p_b[9] ? 10'(-p_b) : 10'(p_b);
    abs_c = p_c[9] ? 10'(-p_c) : 10'(p_c);
    if (abs_a <= abs_b && abs_a <= abs_c) begin
      paeth = ctl_i.left;
    end else if (abs_b <= abs_c) begin
      paeth = ctl_i.up;
    end else begin
      paeth = ctl_i.upleft;
    end
    unique case (ctl_i.filt)
      FILT_SUB:   pred = ctl_i.left;
      FILT_UP:    pred = ctl_i.up;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth;
      default:    pred = 8'd0;
    endcase
    pix_o = raw_i + pred;
  end

endmodule

### rtl/psu_line_store.sv
// Line store holding the previous row of reconstructed pixels, with a
// registered read port and write-to-read forwarding. Depends on psu_pkg.
module psu_line_store (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [psu_pkg::ColW-1:0] waddr_i,
  input  psu_pkg::pix_word_t      wdata_i,
  input  logic                    re_i,
  input  logic [psu_pkg::ColW-1:0] raddr_i,
  output psu_pkg::pix_word_t      rdata_o
);
  import psu_pkg::*;

  pix_word_t mem [MaxWidth];
  pix_word_t rd_q;
  pix_word_t fwd_q;
  logic      fwd_sel_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q      <= mem[raddr_i];
      fwd_q     <= wdata_i;
      fwd_sel_q <= we_i && (waddr_i == raddr_i);
    end
  end

  // A read that meets a write to the same entry returns the new data.
  assign rdata_o = fwd_sel_q ? fwd_q : rd_q;

endmodule

### rtl/png_scanline_unfilter_rgba_unit.sv
// Top level of the PNG scanline unfilter unit for 8-bit RGB/RGBA pixels.
// Depends on psu_pkg, psu_lane and psu_line_store.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o | in_pix_i  (filter + raw RGBA)
//   out     | output    | out_valid_o/out_stall_i | out_pix_o (RGBA + row marks)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pixel per cycle sustained while the output is not stalled. There are two
// register stages: an accepted pixel is held in stage 1 while its line-store
// read completes, and its result is then registered in the output register.
// The rate is set by the left-neighbour loop: each pixel's result is computed
// through the four channel lanes and registered for the next pixel's predictor.
// Reset clears counters, valid flags and configuration (width 1, height 1,
// RGBA); the line store is not cleared and the first row never uses its data.
// A stalled output holds the result; the pipeline stage behind it then stalls
// the input, so no transaction is lost or repeated.
module png_scanline_unfilter_rgba_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  psu_pkg::in_pix_t             in_pix_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output psu_pkg::out_pix_t            out_pix_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [psu_pkg::CfgDataW-1:0] cfg_data_i
);
  import psu_pkg::*;

  // Configuration registers.
  logic [CfgWidthW-1:0]  width_q;
  logic [CfgHeightW-1:0] height_q;
  logic                  alpha_q;

  // Raster position of the next pixel to be accepted.
  logic [ColW-1:0]       col_q, col_d;
  logic [CfgHeightW-1:0] row_q, row_d;

  // Stage 1: the accepted pixel waiting for its line-store read data.
  logic                  s1_valid_q;
  in_pix_t               s1_pix_q;
  logic [ColW-1:0]       s1_col_q;
  logic                  s1_first_col_q;
  logic                  s1_first_row_q;
  logic                  s1_eor_q;
  logic                  s1_last_q;

  // Neighbour registers carried from one pixel to the next.
  pix_word_t             left_q;
  pix_word_t             ul_q;

  // Output register.
  logic                  out_valid_q;
  out_pix_t              out_pix_q;

  logic                  in_acc;
  logic                  s1_adv;
  logic [CfgWidthW-1:0]  w_eff;
  logic [CfgHeightW-1:0] h_eff;
  logic                  eor;
  logic                  last;
  pix_word_t             mem_up;
  pix_word_t             up_px;
  pix_word_t             left_px;
  pix_word_t             ul_px;
  pix_word_t             raw_px;
  pix_word_t             lane_px;
  pix_word_t             result;
  logic                  bad;
  filt_e                 filt;
  lane_ctl_t             lane_ctl [NumLanes];

  // The stage-1 pixel moves on whenever the output register is free or is
  // being emptied in this cycle; the input is stalled only when it cannot.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration writes. Writes to an index beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgWidthW'(1);
      height_q <= CfgHeightW'(1);
      alpha_q  <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i[CfgWidthW-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[CfgHeightW-1:0];
        CFG_ALPHA:  alpha_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Row and image marks come from the counters at acceptance time. A zero
  // width or height acts as one, and a width past the store is saturated.
  always_comb begin
    w_eff = width_q;
    if (width_q == '0) begin
      w_eff = CfgWidthW'(1);
    end else if (32'(width_q) > MaxWidth) begin
      w_eff = CfgWidthW'(MaxWidth);
    end
    h_eff = (height_q == '0) ? CfgHeightW'(1) : height_q;
    eor   = (32'(col_q) + 32'd1) >= 32'(w_eff);
    last  = eor && ((32'(row_q) + 32'd1) >= 32'(h_eff));
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (eor) begin
        col_d = '0;
        row_d = last ? '0 : CfgHeightW'(32'(row_q) + 32'd1);
      end else begin
        col_d = ColW'(32'(col_q) + 32'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      ul_q        <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        left_q      <= result;
        ul_q        <= up_px;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q       <= in_pix_i;
      s1_col_q       <= col_q;
      s1_first_col_q <= (col_q == '0);
      s1_first_row_q <= (row_q == '0);
      s1_eor_q       <= eor;
      s1_last_q      <= last;
    end
    if (s1_adv) begin
      out_pix_q.pix_red    <= result[0];
      out_pix_q.pix_green  <= result[1];
      out_pix_q.pix_blue   <= result[2];
      out_pix_q.pix_alpha  <= result[3];
      out_pix_q.end_of_row <= s1_eor_q;
      out_pix_q.last_pixel <= s1_last_q;
      out_pix_q.bad_filter <= bad;
    end
  end

  // The read for a pixel is issued as it is accepted; the write of the pixel
  // ahead of it lands in the same cycle, and the store forwards it when both name the same column.
  psu_line_store u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (result),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (mem_up)
  );

  // Neighbours outside the image read as zero.
  assign up_px   = s1_first_row_q ? '0 : mem_up;
  assign left_px = s1_first_col_q ? '0 : left_q;
  assign ul_px   = (s1_first_row_q || s1_first_col_q) ? '0 : ul_q;

  assign bad    = s1_pix_q.filter_type > 8'd4;
  assign filt   = bad ? FILT_NONE : filt_e'(s1_pix_q.filter_type[2:0]);
  assign raw_px = {s1_pix_q.raw_alpha, s1_pix_q.raw_blue,
                   s1_pix_q.raw_green, s1_pix_q.raw_red};

  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    assign lane_ctl[k] = '{filt:   filt,
                           left:   left_px[k],
                           up:     up_px[k],
                           upleft: ul_px[k]};
    psu_lane u_lane (
      .ctl_i (lane_ctl[k]),
      .raw_i (raw_px[k]),
      .pix_o (lane_px[k])
    );
  end

  // Merge the lanes: a bad filter zeroes every channel, and RGB mode forces
  // alpha to opaque. The merged word is also what later pixels see.
  always_comb begin
    result = bad ? '0 : lane_px;
    if (!alpha_q) begin
      result[NumLanes-1] = 8'hFF;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;

endmodule

### rtl/psu_checker.sv
// Port-level checker for the PNG scanline unfilter unit, bound to the top
// level. Depends on psu_pkg and png_scanline_unfilter_rgba_unit.
module psu_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input psu_pkg::out_pix_t            out_pix_o
);
  import psu_pkg::*;

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_pix_o))
    else $error("output transaction changed while stalled");

  // The input is held back only by a full, stalled output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // The last pixel of an image always closes its row.
  a_last_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_pix_o.last_pixel |-> out_pix_o.end_of_row)
    else $error("last pixel without end of row");

  // A bad filter produces black color channels.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_pix_o.bad_filter |->
      out_pix_o.pix_red == 8'd0 && out_pix_o.pix_green == 8'd0 &&
      out_pix_o.pix_blue == 8'd0)
    else $error("bad filter with nonzero color");

endmodule

bind png_scanline_unfilter_rgba_unit psu_checker u_psu_checker (.*);
